// File: src/bass_pkg.sv
// Package for the boom angle servo stepper: limits, phase codes and the angle table.
`default_nettype none

package bass_pkg;

	localparam int ADC_WIDTH_DEF = 10;

	localparam int DUTY_W = 12;
	localparam int ANGLE_W = 7;
	localparam int REACH_W = 7;
	localparam int TENTHS_W = 14;
	localparam int FB_OUT_W = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [DUTY_W-1:0] DUTY_MIN_RST = 12'd1658;
	localparam logic [DUTY_W-1:0] DUTY_MAX_RST = 12'd3870;
	localparam logic [DUTY_W-1:0] DUTY_START_RST = 12'd2500;
	localparam logic [REACH_W-1:0] REACH_RST = 7'd45;
	localparam logic [REACH_W-1:0] REACH_LO = 7'd40;
	localparam logic [REACH_W-1:0] REACH_HI = 7'd100;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX = 7'd70;

	// Feedback offset and scale: trunc((610 - s) / 3) + 25
	localparam int FB_ZERO = 610;
	localparam int FB_OFFSET = 25;
	// ceil(2^13 / 3); exact quotient by 3 for magnitudes below 2^13
	localparam int RECIP3_SHIFT = 13;
	localparam logic [11:0] RECIP3 = 12'd2731;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_START = 2'd2;

	// Reported motion codes
	localparam logic [1:0] MOVE_IDLE = 2'd0;
	localparam logic [1:0] MOVE_DOWN = 2'd1;
	localparam logic [1:0] MOVE_UP = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_DOWN = 3'b010,
		PH_UP   = 3'b100
	} phase_t;

	// trunc(acos(t/120)*180/3.1416) for t = 40 + idx
	function automatic logic [ANGLE_W-1:0] angle_lut(input logic [5:0] idx);
		logic [ANGLE_W-1:0] a;
		case (idx)
			6'd0, 6'd1:                 a = 7'd70;
			6'd2, 6'd3:                 a = 7'd69;
			6'd4:                       a = 7'd68;
			6'd5, 6'd6:                 a = 7'd67;
			6'd7, 6'd8:                 a = 7'd66;
			6'd9, 6'd10:                a = 7'd65;
			6'd11, 6'd12:               a = 7'd64;
			6'd13, 6'd14:               a = 7'd63;
			6'd15, 6'd16:               a = 7'd62;
			6'd17, 6'd18:               a = 7'd61;
			6'd19:                      a = 7'd60;
			6'd20, 6'd21:               a = 7'd59;
			6'd22, 6'd23:               a = 7'd58;
			6'd24, 6'd25:               a = 7'd57;
			6'd26, 6'd27:               a = 7'd56;
			6'd28:                      a = 7'd55;
			6'd29, 6'd30:               a = 7'd54;
			6'd31, 6'd32:               a = 7'd53;
			6'd33:                      a = 7'd52;
			6'd34, 6'd35:               a = 7'd51;
			6'd36, 6'd37:               a = 7'd50;
			6'd38:                      a = 7'd49;
			6'd39, 6'd40:               a = 7'd48;
			6'd41:                      a = 7'd47;
			6'd42, 6'd43:               a = 7'd46;
			6'd44:                      a = 7'd45;
			6'd45, 6'd46:               a = 7'd44;
			6'd47:                      a = 7'd43;
			6'd48, 6'd49:               a = 7'd42;
			6'd50:                      a = 7'd41;
			6'd51:                      a = 7'd40;
			6'd52, 6'd53:               a = 7'd39;
			6'd54:                      a = 7'd38;
			6'd55:                      a = 7'd37;
			6'd56, 6'd57:               a = 7'd36;
			6'd58:                      a = 7'd35;
			6'd59:                      a = 7'd34;
			default:                    a = 7'd33;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// File: src/boom_angle_servo_stepper.sv
// Boom angle servo stepper: sample register, one-pass duty update, result register.
`default_nettype none

// Channel   Handshake             Payload
// in        in_valid / in_ready   adc_sample, target_tenths, target_present, cmd
// out       out_valid / out_ready duty, feedback_angle, target_angle, moving
// cfg       cfg_we (no wait)      cfg_index, cfg_data
//
// One item per cycle unless out_ready stalls; items pass sample then result register.
// The rate is set by the single pass from the sample register through the feedback
// divide-by-three (one reciprocal multiply) and the duty step into the result register.
// Reset loads the register defaults, puts the stepper idle and presets the duty.
// A stalled result holds in its register while the sample register still takes one
// more item; the input side stops only when both are full.

module boom_angle_servo_stepper
	import bass_pkg::*;
#(
	parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [ADC_WIDTH-1:0]   adc_sample,
	input  wire logic [TENTHS_W-1:0]    target_tenths,
	input  wire logic                   target_present,
	input  wire logic                   cmd,

	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [DUTY_W-1:0]           duty,
	output logic signed [FB_OUT_W-1:0]  feedback_angle,
	output logic [ANGLE_W-1:0]          target_angle,
	output logic [1:0]                  moving,

	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [DUTY_W-1:0]      cfg_data
);

	// Sample magnitude width: room for the sample and for the 610 offset
	localparam int SW = ((ADC_WIDTH > 10) ? ADC_WIDTH : 10) + 1;
	localparam int PW = SW + 12;

	// Configuration
	logic [DUTY_W-1:0] duty_min_q, duty_max_q;

	// Stepper state
	phase_t             phase_q;
	logic [DUTY_W-1:0]  duty_count_q;
	logic [ANGLE_W-1:0] goal_q;
	logic [REACH_W-1:0] reach_cur_q, reach_done_q;

	// Sample register
	logic                 valid_s1;
	logic [ADC_WIDTH-1:0] adc_s1;
	logic [TENTHS_W-1:0]  tenths_s1;
	logic                 present_s1;
	logic                 cmd_s1;

	// Result register
	logic                       out_valid_q;
	logic [DUTY_W-1:0]          duty_q;
	logic signed [FB_OUT_W-1:0] fb_q;
	logic [ANGLE_W-1:0]         angle_q;
	logic [1:0]                 moving_q;

	logic advance, step_en;

	assign advance  = !out_valid_q || out_ready;
	assign step_en  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Feedback angle: truncate toward zero by dividing the magnitude
	logic signed [SW:0]  diff;
	logic [SW-1:0]       mag;
	logic [PW-1:0]       prod;
	logic [SW-2:0]       quot;
	logic signed [SW:0]  quot_s, fb;
	logic signed [SW:0]  goal_s;

	always_comb begin
		diff   = signed'((SW+1)'(FB_ZERO)) - signed'({{(SW+1-ADC_WIDTH){1'b0}}, adc_s1});
		mag    = diff[SW] ? SW'(-diff) : diff[SW-1:0];
		prod   = PW'(mag) * PW'(RECIP3);
		quot   = prod[RECIP3_SHIFT +: (SW-1)];
		quot_s = signed'({2'b00, quot});
		fb     = (diff[SW] ? -quot_s : quot_s) + signed'((SW+1)'(FB_OFFSET));
	end

	// Next state for the item in the sample register
	phase_t             ph_n;
	logic [DUTY_W-1:0]  duty_n;
	logic [ANGLE_W-1:0] goal_n;
	logic [REACH_W-1:0] reach_cur_n, reach_done_n;
	logic [REACH_W-1:0] reach_idx;
	logic               blocked, start;
	logic [DUTY_W:0]    duty_up;
	logic [1:0]         moving_n;

	always_comb begin
		ph_n         = phase_q;
		duty_n       = duty_count_q;
		goal_n       = goal_q;
		reach_cur_n  = reach_cur_q;
		reach_done_n = reach_done_q;
		blocked      = 1'b0;
		start        = 1'b0;
		reach_idx    = '0;

		// Idle: take a new reach and maybe start a move
		if (phase_q == PH_IDLE) begin
			if (present_s1) begin
				reach_cur_n = (tenths_s1 >= TENTHS_W'(REACH_LO) &&
					tenths_s1 <= TENTHS_W'(REACH_HI)) ? tenths_s1[REACH_W-1:0]
					: reach_done_q;
				blocked = (reach_cur_n == reach_done_q);
			end
			start = cmd_s1 && !blocked;
		end

		if (reach_cur_n < REACH_LO) begin
			reach_idx = '0;
		end else if (reach_cur_n > REACH_HI) begin
			reach_idx = REACH_HI - REACH_LO;
		end else begin
			reach_idx = reach_cur_n - REACH_LO;
		end

		if (start) begin
			goal_n = angle_lut(reach_idx[5:0]);
			ph_n   = PH_DOWN;
		end

		goal_s = signed'({{(SW+1-ANGLE_W){1'b0}}, goal_n});

		// Down phase: step down while above, else fall through to up
		if (ph_n == PH_DOWN) begin
			if (fb > goal_s) begin
				if (duty_count_q == '0 || (duty_count_q - 1'b1) < duty_min_q) begin
					duty_n = duty_min_q;
				end else begin
					duty_n = duty_count_q - 1'b1;
				end
			end else begin
				ph_n = PH_UP;
			end
		end

		// Up phase: step up while below, else end the move
		duty_up = {1'b0, duty_n} + 1'b1;
		if (ph_n == PH_UP) begin
			if (fb < goal_s) begin
				duty_n = (duty_up > {1'b0, duty_max_q}) ? duty_max_q : duty_up[DUTY_W-1:0];
			end else begin
				ph_n         = PH_IDLE;
				reach_done_n = reach_cur_n;
			end
		end

		case (ph_n)
			PH_DOWN: moving_n = MOVE_DOWN;
			PH_UP:   moving_n = MOVE_UP;
			default: moving_n = MOVE_IDLE;
		endcase
	end

	// Configuration registers and stepper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_min_q   <= DUTY_MIN_RST;
			duty_max_q   <= DUTY_MAX_RST;
			phase_q      <= PH_IDLE;
			duty_count_q <= DUTY_START_RST;
			goal_q       <= '0;
			reach_cur_q  <= REACH_RST;
			reach_done_q <= REACH_RST;
		end else begin
			if (step_en) begin
				phase_q      <= ph_n;
				duty_count_q <= duty_n;
				goal_q       <= goal_n;
				reach_cur_q  <= reach_cur_n;
				reach_done_q <= reach_done_n;
			end
			// The user must write only while idle, unchecked; duty_start writes preset the duty
			if (cfg_we) begin
				case (cfg_index)
					CFG_DUTY_MIN:   duty_min_q <= cfg_data;
					CFG_DUTY_MAX:   duty_max_q <= cfg_data;
					CFG_DUTY_START: duty_count_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Sample register: load on transfer, drain when the result register frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			adc_s1     <= adc_sample;
			tenths_s1  <= target_tenths;
			present_s1 <= target_present;
			cmd_s1     <= cmd;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			duty_q   <= duty_n;
			fb_q     <= fb[FB_OUT_W-1:0];
			angle_q  <= goal_n;
			moving_q <= moving_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign duty           = duty_q;
	assign feedback_angle = fb_q;
	assign target_angle   = angle_q;
	assign moving         = moving_q;

	// An idle stepper with no move request stays idle
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == PH_IDLE && !cmd_s1 |=> phase_q == PH_IDLE)
		else $error("stepper left idle without a move request");

	// The input side never stalls while the result register is empty
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty result register");

	// Goal angles come only from the table
	a_goal_range: assert property (@(posedge clk) disable iff (!arst_n)
		goal_q <= ANGLE_MAX)
		else $error("goal angle outside the table range");

endmodule

`default_nettype wire
